@@ rtl/tcg_pkg.sv @@
// ----------------------------------------------------------------------------
// tcg_pkg: shared types and constants of the text console glyph renderer
// Field widths, command and result codes, register map and the structs that
// pass between the register block, the sequencer and the pixel pipeline.
// ----------------------------------------------------------------------------
package tcg_pkg;

  // Fixed field widths
  localparam int CMD_W      = 2;
  localparam int CH_W       = 8;
  localparam int GLINE_W    = 4;
  localparam int GBITS_W    = 8;
  localparam int KIND_W     = 2;
  localparam int OFF_W      = 28;
  localparam int PIX_W      = 24;
  localparam int NPIX       = 8;
  localparam int COLS_W     = 10;
  localparam int ROWS_W     = 9;
  localparam int PITCH_W    = 16;
  localparam int IN_DATA_W  = 24;   // 20 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 224;  // 220 bits of fields, padded to bytes
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;

  // Register reset values
  localparam logic [COLS_W-1:0]  RST_COLUMNS = 10'd128;
  localparam logic [ROWS_W-1:0]  RST_ROWS    = 9'd48;
  localparam logic [PITCH_W-1:0] RST_PITCH   = 16'd4096;
  localparam logic [PIX_W-1:0]   RST_FORE    = 24'hCCCCCC;
  localparam logic [PIX_W-1:0]   RST_BACK    = 24'h000000;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_COLUMNS = 3'd1;
  localparam logic [2:0] REG_ROWS    = 3'd2;
  localparam logic [2:0] REG_PITCH   = 3'd3;
  localparam logic [2:0] REG_FORE    = 3'd4;
  localparam logic [2:0] REG_BACK    = 3'd5;

  // Control characters that move the cursor
  localparam logic [CH_W-1:0] CH_TAB = 8'h09;
  localparam logic [CH_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR  = 8'h0D;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GLYPH,
    ST_CMD
  } seq_state_t;

  typedef struct packed {
    logic               enable;
    logic [COLS_W-1:0]  text_columns;
    logic [ROWS_W-1:0]  text_rows;
    logic [PITCH_W-1:0] line_pitch;
    logic [PIX_W-1:0]   fore_colour;
    logic [PIX_W-1:0]   back_colour;
  } cfg_t;

  // Control part of one issued result token
  typedef struct packed {
    kind_e kind;
    logic  last;
    logic  glyph_ok;
  } tok_t;

  typedef struct packed {
    kind_e                      kind;
    logic                       last;
    logic [NPIX-1:0][PIX_W-1:0] pix;
    logic [OFF_W-1:0]           offset;
  } res_t;

endpackage

@@ rtl/tcg_regs.sv @@
// ----------------------------------------------------------------------------
// tcg_regs: APB configuration registers
// Six registers at byte addresses 0..20, written on the access phase, read
// back with zero extension. pready is always high.
// ----------------------------------------------------------------------------
module tcg_regs
  import tcg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx        = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= 1'b0;
      cfg_r.text_columns <= RST_COLUMNS;
      cfg_r.text_rows    <= RST_ROWS;
      cfg_r.line_pitch   <= RST_PITCH;
      cfg_r.fore_colour  <= RST_FORE;
      cfg_r.back_colour  <= RST_BACK;
    end else if (wr) begin
      unique case (idx)
        REG_ENABLE:  cfg_r.enable       <= cfg_pwdata[0];
        REG_COLUMNS: cfg_r.text_columns <= cfg_pwdata[COLS_W-1:0];
        REG_ROWS:    cfg_r.text_rows    <= cfg_pwdata[ROWS_W-1:0];
        REG_PITCH:   cfg_r.line_pitch   <= cfg_pwdata[PITCH_W-1:0];
        REG_FORE:    cfg_r.fore_colour  <= cfg_pwdata[PIX_W-1:0];
        REG_BACK:    cfg_r.back_colour  <= cfg_pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_ENABLE:  cfg_prdata = APB_DW'(cfg_r.enable);
      REG_COLUMNS: cfg_prdata = APB_DW'(cfg_r.text_columns);
      REG_ROWS:    cfg_prdata = APB_DW'(cfg_r.text_rows);
      REG_PITCH:   cfg_prdata = APB_DW'(cfg_r.line_pitch);
      REG_FORE:    cfg_prdata = APB_DW'(cfg_r.fore_colour);
      REG_BACK:    cfg_prdata = APB_DW'(cfg_r.back_colour);
      default:     cfg_prdata = '0;
    endcase
  end

endmodule

@@ rtl/tcg_font_ram.sv @@
// ----------------------------------------------------------------------------
// tcg_font_ram: glyph row store
// One write port, one registered read port (read-first). After reset a sweep
// writes zero to every entry, one per cycle, and flags itself busy.
// ----------------------------------------------------------------------------
module tcg_font_ram
  import tcg_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [GBITS_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [GBITS_W-1:0] rd_data,
  output logic               clr_busy
);

  logic [GBITS_W-1:0] mem [DEPTH];
  logic [GBITS_W-1:0] rd_data_r;
  logic [AW-1:0]      clr_addr_r;
  logic               clr_busy_r;

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // storage: sweep has the write port while busy
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // the sweep runs once per reset
  a_sweep_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |=> !clr_busy_r)
    else $error("font clear sweep restarted");

endmodule

@@ rtl/tcg_engine.sv @@
// ----------------------------------------------------------------------------
// tcg_engine: command decode, cursor and result sequencer
// Decodes each input transaction, keeps the cursor, writes font rows and
// issues one result token per cycle while the pixel pipeline advances (glyph row reads or a scroll/clear).
// ----------------------------------------------------------------------------
module tcg_engine
  import tcg_pkg::*;
#(
  parameter int FONT_CHARS   = 256,
  parameter int GLYPH_HEIGHT = 16,
  parameter int COL_W        = 9,
  parameter int ROW_W        = 8,
  parameter int LINE_W       = 4,
  parameter int PY_W         = 12,
  parameter int FA_W         = 12,
  parameter int MAX_COLUMNS  = 512,
  parameter int MAX_ROWS     = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 adv,
  input  logic                 clr_busy,
  // input transactions
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [CMD_W-1:0]     in_tuser,
  // font write
  output logic                 wr_en,
  output logic [FA_W-1:0]      wr_addr,
  output logic [GBITS_W-1:0]   wr_data,
  // token issue
  output logic [FA_W-1:0]      rd_addr,
  output logic                 tok_valid,
  output tok_t                 tok,
  output logic [PY_W-1:0]      tok_py,
  output logic [COL_W-1:0]     tok_col
);

  seq_state_t          state_r, state_nxt;
  logic [LINE_W-1:0]   y_r, y_nxt;
  kind_e               cmd_kind_r, cmd_kind_nxt;
  logic [CH_W-1:0]     ch_r;
  logic [ROW_W-1:0]    ren_row_r;
  logic [COL_W-1:0]    ren_col_r;
  logic                glyph_ok_r;
  logic                scroll_pend_r;
  logic [COL_W-1:0]    cursor_col_r, cursor_col_nxt;
  logic [ROW_W-1:0]    cursor_row_r, cursor_row_nxt;

  logic [CH_W-1:0]     in_ch;
  logic [GLINE_W-1:0]  in_gline;
  logic [GBITS_W-1:0]  in_gbits;
  logic                acc;
  logic                y_last;
  logic                in_glyph_ok;

  // decode results
  logic                dec_glyph;
  logic                dec_cmd;
  kind_e               dec_kind;
  logic                dec_scroll;
  logic                nl;
  logic [COLS_W-1:0]   eff_cols;
  logic [ROWS_W-1:0]   eff_rows;
  logic [COLS_W-1:0]   nc;
  logic [ROWS_W-1:0]   nr;

  assign in_ch    = in_tdata[7:0];
  assign in_gline = in_tdata[11:8];
  assign in_gbits = in_tdata[19:12];

  assign y_last    = (y_r == LINE_W'(GLYPH_HEIGHT - 1));
  assign in_tready = adv && !clr_busy &&
                     (state_r == ST_IDLE || state_r == ST_CMD ||
                      (state_r == ST_GLYPH && y_last && !scroll_pend_r));
  assign acc       = in_tvalid && in_tready;
  assign in_glyph_ok = ({1'b0, in_ch} < 9'(FONT_CHARS));

  // font row load, independent of enable
  assign wr_en   = acc && (in_tuser == CMD_LOAD) && in_glyph_ok &&
                   ({1'b0, in_gline} < 5'(GLYPH_HEIGHT));
  assign wr_addr = FA_W'(in_ch * GLYPH_HEIGHT + in_gline);
  assign wr_data = in_gbits;

  // effective geometry
  always_comb begin
    if (cfg.text_columns == '0) begin
      eff_cols = COLS_W'(1);
    end else if (cfg.text_columns > COLS_W'(MAX_COLUMNS)) begin
      eff_cols = COLS_W'(MAX_COLUMNS);
    end else begin
      eff_cols = cfg.text_columns;
    end
    if (cfg.text_rows == '0) begin
      eff_rows = ROWS_W'(1);
    end else if (cfg.text_rows > ROWS_W'(MAX_ROWS)) begin
      eff_rows = ROWS_W'(MAX_ROWS);
    end else begin
      eff_rows = cfg.text_rows;
    end
  end

  // cursor movement for an accepted put or clear
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    dec_glyph      = 1'b0;
    dec_cmd        = 1'b0;
    dec_kind       = KIND_SCROLL;
    dec_scroll     = 1'b0;
    nl             = 1'b0;
    nc             = '0;
    nr             = ROWS_W'(cursor_row_r) + ROWS_W'(1);
    if (acc && cfg.enable && in_tuser == CMD_CLEAR) begin
      cursor_col_nxt = '0;
      cursor_row_nxt = '0;
      dec_cmd        = 1'b1;
      dec_kind       = KIND_CLEAR;
    end else if (acc && cfg.enable && in_tuser == CMD_PUT) begin
      priority if (in_ch == CH_LF) begin
        nl = 1'b1;
      end else if (in_ch == CH_CR) begin
        cursor_col_nxt = '0;
      end else if (in_ch == CH_TAB) begin
        nc = (COLS_W'(cursor_col_r) + COLS_W'(8)) & ~COLS_W'(7);
        if (nc >= eff_cols) begin
          nl = 1'b1;
        end else begin
          cursor_col_nxt = COL_W'(nc);
        end
      end else begin
        dec_glyph = 1'b1;
        nc = COLS_W'(cursor_col_r) + COLS_W'(1);
        if (nc >= eff_cols) begin
          nl = 1'b1;
        end else begin
          cursor_col_nxt = COL_W'(nc);
        end
      end
      // next line, scroll when past the last row
      if (nl) begin
        cursor_col_nxt = '0;
        if (nr >= eff_rows) begin
          cursor_row_nxt = ROW_W'(eff_rows - ROWS_W'(1));
          dec_scroll     = 1'b1;
        end else begin
          cursor_row_nxt = ROW_W'(nr);
        end
      end
      dec_cmd = dec_scroll && !dec_glyph;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt    = state_r;
    y_nxt        = y_r;
    cmd_kind_nxt = cmd_kind_r;
    unique case (state_r)
      ST_IDLE: ;
      ST_GLYPH: begin
        if (adv) begin
          if (y_last) begin
            state_nxt    = scroll_pend_r ? ST_CMD : ST_IDLE;
            cmd_kind_nxt = KIND_SCROLL;
          end else begin
            y_nxt = y_r + LINE_W'(1);
          end
        end
      end
      ST_CMD: begin
        if (adv) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (dec_glyph) begin
      state_nxt = ST_GLYPH;
      y_nxt     = '0;
    end else if (dec_cmd) begin
      state_nxt    = ST_CMD;
      cmd_kind_nxt = dec_kind;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      y_r           <= '0;
      cmd_kind_r    <= KIND_SCROLL;
      scroll_pend_r <= 1'b0;
      cursor_col_r  <= '0;
      cursor_row_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      y_r          <= y_nxt;
      cmd_kind_r   <= cmd_kind_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      if (dec_glyph) begin
        scroll_pend_r <= dec_scroll;
      end
    end
  end

  // render context, captured as the cursor moves on
  always_ff @(posedge clk) begin
    if (dec_glyph) begin
      ch_r       <= in_ch;
      ren_row_r  <= cursor_row_r;
      ren_col_r  <= cursor_col_r;
      glyph_ok_r <= in_glyph_ok;
    end
  end

  // token issue
  assign tok_valid    = (state_r == ST_GLYPH) || (state_r == ST_CMD);
  assign tok.kind     = (state_r == ST_GLYPH) ? KIND_PIXEL : cmd_kind_r;
  assign tok.last     = (state_r == ST_GLYPH) ? (y_last && !scroll_pend_r) : 1'b1;
  assign tok.glyph_ok = glyph_ok_r;
  assign tok_py       = PY_W'(ren_row_r * GLYPH_HEIGHT) + PY_W'(y_r);
  assign tok_col      = ren_col_r;
  assign rd_addr      = FA_W'(ch_r * GLYPH_HEIGHT + y_r);

  // scroll and clear always close their item
  a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_valid && tok.kind != KIND_PIXEL) |-> tok.last)
    else $error("command token without last");

  // cursor stays inside the maximum geometry
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (COLS_W'(cursor_col_r) < COLS_W'(MAX_COLUMNS)) &&
    (ROWS_W'(cursor_row_r) < ROWS_W'(MAX_ROWS)))
    else $error("cursor out of range");

endmodule

@@ rtl/tcg_pixel_pipe.sv @@
// ----------------------------------------------------------------------------
// tcg_pixel_pipe: offset and pixel pipeline with output skid buffer
// Stage B holds the token while the font row is read, stage C holds the
// pitch product, then offset add and colour expansion into the output.
// ----------------------------------------------------------------------------
module tcg_pixel_pipe
  import tcg_pkg::*;
#(
  parameter int PY_W  = 12,
  parameter int COL_W = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  tok_valid,
  input  tok_t                  tok,
  input  logic [PY_W-1:0]       tok_py,
  input  logic [COL_W-1:0]      tok_col,
  input  logic [GBITS_W-1:0]    rd_data,
  output logic                  adv,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]     out_tuser,
  output logic                  out_tlast
);

  localparam int PROD_W = PY_W + PITCH_W;

  logic               b_valid_r;
  tok_t               b_tok_r;
  logic [PY_W-1:0]    b_py_r;
  logic [COL_W-1:0]   b_col_r;

  logic               c_valid_r;
  tok_t               c_tok_r;
  logic [PROD_W-1:0]  c_prod_r;
  logic [COL_W-1:0]   c_col_r;
  logic [GBITS_W-1:0] c_bits_r;

  res_t               res;
  res_t               out_r;
  res_t               skid_r;
  logic               out_valid_r;
  logic               skid_valid_r;
  logic               push;

  // pipeline moves while the skid stage is free
  assign adv  = !skid_valid_r;
  assign push = c_valid_r && adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= tok_valid;
      c_valid_r <= b_valid_r;
    end
  end

  // stage payloads: pitch multiply, glyph bits masked for missing glyphs
  always_ff @(posedge clk) begin
    if (adv) begin
      b_tok_r  <= tok;
      b_py_r   <= tok_py;
      b_col_r  <= tok_col;
      c_tok_r  <= b_tok_r;
      c_prod_r <= PROD_W'(b_py_r) * PROD_W'(cfg.line_pitch);
      c_col_r  <= b_col_r;
      c_bits_r <= b_tok_r.glyph_ok ? rd_data : '0;
    end
  end

  // offset add and colour expansion
  always_comb begin
    res.kind   = c_tok_r.kind;
    res.last   = c_tok_r.last;
    res.offset = '0;
    res.pix    = '0;
    if (c_tok_r.kind == KIND_PIXEL) begin
      res.offset = OFF_W'(c_prod_r) + OFF_W'({c_col_r, 5'b0});
      for (int i = 0; i < NPIX; i++) begin
        res.pix[i] = c_bits_r[NPIX-1-i] ? cfg.fore_colour : cfg.back_colour;
      end
    end
  end

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {4'b0, out_r.pix, out_r.offset};

  // skid holds a transaction only behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage filled ahead of output");

  // scroll and clear carry no offset or pixels
  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind != KIND_PIXEL) |-> (out_tdata == '0))
    else $error("command result with payload");

endmodule

@@ rtl/text_console_glyph_renderer_top.sv @@
// Path: a glyph's first row write passes the engine state register, pipeline stages B
//   and C and the output register. A printable character issues one font store read
//   per glyph row and then a scroll token when it scrolls; clears issue one token each.
// The single read port of the font store sets the rate of one row write per cycle while the pipeline advances.
// Reset: control state and registers clear at once; then a sweep zeroes all FONT_CHARS*GLYPH_HEIGHT
//   entries (4096 by default) of the font store with in_tready held low.
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top: text console glyph renderer
// Cursor handling, font store and row-write generation for an 8-pixel wide
// character cell console, with an APB configuration port.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top
  import tcg_pkg::*;
#(
  parameter int FONT_CHARS   = 256,
  parameter int GLYPH_HEIGHT = 16,
  parameter int MAX_COLUMNS  = 512,
  parameter int MAX_ROWS     = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input: tdata = char_code[7:0], glyph_line[11:8], glyph_bits[19:12]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,   // command
  // output: tdata = byte_offset[27:0], pix0[51:28] .. pix7[219:196]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]     out_tuser,  // kind
  output logic                  out_tlast,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_AW-1:0]     cfg_paddr,
  input  logic [APB_DW-1:0]     cfg_pwdata,
  output logic [APB_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  localparam int FONT_DEPTH = FONT_CHARS * GLYPH_HEIGHT;
  localparam int FA_W       = $clog2(FONT_DEPTH);
  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int LINE_W     = $clog2(GLYPH_HEIGHT);
  localparam int PY_W       = $clog2(MAX_ROWS * GLYPH_HEIGHT);

  cfg_t               cfg;
  logic               adv;
  logic               clr_busy;
  logic               wr_en;
  logic [FA_W-1:0]    wr_addr;
  logic [GBITS_W-1:0] wr_data;
  logic [FA_W-1:0]    rd_addr;
  logic [GBITS_W-1:0] rd_data;
  logic               tok_valid;
  tok_t               tok;
  logic [PY_W-1:0]    tok_py;
  logic [COL_W-1:0]   tok_col;

  tcg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tcg_font_ram #(
    .DEPTH (FONT_DEPTH),
    .AW    (FA_W)
  ) u_font (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (adv),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  tcg_engine #(
    .FONT_CHARS   (FONT_CHARS),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .COL_W        (COL_W),
    .ROW_W        (ROW_W),
    .LINE_W       (LINE_W),
    .PY_W         (PY_W),
    .FA_W         (FA_W),
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .adv       (adv),
    .clr_busy  (clr_busy),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_py    (tok_py),
    .tok_col   (tok_col)
  );

  tcg_pixel_pipe #(
    .PY_W  (PY_W),
    .COL_W (COL_W)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .tok_valid  (tok_valid),
    .tok        (tok),
    .tok_py     (tok_py),
    .tok_col    (tok_col),
    .rd_data    (rd_data),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
